// ----- rtl/core/bbr_pkg.sv -----
// Shared types, constants and register codes of the 3x3 RGB box blur.
package bbr_pkg;

  // Default line length the line store is sized for.
  localparam int MAX_WIDTH_DEF = 1024;

  // Pixel and channel widths.
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Row counter width and frame width and height limits.
  localparam int RW         = 13;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;
  localparam int MAX_HEIGHT = 4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_W_BITS = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Request command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Window sum and the divide by nine as a multiply by 3641 / 2^15.
  localparam int SUM_W      = 12;
  localparam int MUL9_W     = 24;
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;

  // Control into the serial divider.
  typedef struct packed {
    logic start;
    logic clear;
  } div_ctl_t;

  // Status out of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- rtl/core/bbr_if.sv -----
// Handshake channel interfaces for pixel requests, blurred results and configuration writes.
interface bbr_pix_if import bbr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface bbr_res_if import bbr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface bbr_cfg_if import bbr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/bbr_div.sv -----
// Serial restoring divider, one quotient bit per cycle, for column folding.
module bbr_div import bbr_pkg::*; #(
  parameter int CW = $clog2(MAX_WIDTH_DEF),
  parameter int WW = $clog2(MAX_WIDTH_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [CW-1:0] dividend,
  input  logic [WW-1:0] divisor,
  output div_sts_t      sts,
  output logic [CW-1:0] quot,
  output logic [WW-1:0] rem
);

  localparam int CNTW = $clog2(CW + 1);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_DONE = 2'd2;

  logic [1:0]      state_r;
  logic [CNTW-1:0] cnt_r;
  logic [CW-1:0]   quo_r;
  logic [WW-1:0]   rem_r;
  logic [WW-1:0]   dvs_r;
  logic [WW:0]     rem_sh;
  logic            fits;
  logic [WW-1:0]   rem_nxt;
  logic [CW-1:0]   quo_nxt;
  logic            load;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign rem_sh  = {rem_r, quo_r[CW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = fits ? WW'(rem_sh - {1'b0, dvs_r}) : WW'(rem_sh);
  assign quo_nxt = {quo_r[CW-2:0], fits};
  assign load    = (state_r == DV_IDLE) && ctl.start && !ctl.clear;

  // Sequencer: idle, run one step per bit, hold the result until cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else if (ctl.clear) begin
      state_r <= DV_IDLE;
    end else begin
      unique case (state_r)
        DV_IDLE: begin
          if (ctl.start) begin
            state_r <= DV_RUN;
            cnt_r   <= CNTW'(CW);
          end
        end
        DV_RUN: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNTW'(1)) begin
            state_r <= DV_DONE;
          end
        end
        DV_DONE: begin
          state_r <= DV_DONE;
        end
        default: begin
          state_r <= DV_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (state_r == DV_RUN) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = (state_r == DV_RUN);
  assign sts.done = (state_r == DV_DONE);
  assign quot     = quo_r;
  assign rem      = rem_r;

endmodule

// ----- rtl/core/box_blur_3x3_rgb_top.sv -----
// Top level of the streaming 3x3 RGB box blur with its line store memory.
//
// Pixels enter in raster order, one request per clock, and each blurred pixel
// leaves with the request that comes frame_width + 1 items after it, so drain
// requests flush the last frame_width + 1 results. Both line stores share one
// MAX_WIDTH x 48-bit memory with a registered read; a request reads its column
// on acceptance and writes the shifted pair back one stage later, with a bypass
// for back-to-back requests to the same column. A result passes stage one,
// stage two and the output register. While the output is taken, the sustained
// rate is one request per clock, except for two cases: the cycle after any
// configuration write, and the first request after a width change that leaves
// the column counter beyond the new width, which waits for the serial divider
// that folds the column. The memory needs no clearing pass after reset.
module box_blur_3x3_rgb_top import bbr_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bbr_pix_if.sink  in_pix,
  bbr_res_if.source out_pix,
  bbr_cfg_if.sink  cfg_wr
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int OCW = CW + RW - 1;
  localparam int OW  = RW + 1;
  localparam int PW  = WW + RW;

  // Position flags of the window center, resolved at acceptance.
  typedef struct packed {
    logic has_out;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } ctl_t;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W_BITS-1:0] v);
    int unsigned vi;
    vi = v;
    if (vi < MIN_WIDTH) begin
      vi = MIN_WIDTH;
    end else if (vi > MAX_WIDTH) begin
      vi = MAX_WIDTH;
    end
    return WW'(vi);
  endfunction

  function automatic logic [RW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    int unsigned vi;
    vi = v;
    if (vi < MIN_HEIGHT) begin
      vi = MIN_HEIGHT;
    end else if (vi > MAX_HEIGHT) begin
      vi = MAX_HEIGHT;
    end
    return RW'(vi);
  endfunction

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [MUL9_W-1:0] p;
    p = MUL9_W'(s) * MUL9_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

  // Configuration and frame size.
  logic [WW-1:0]  w_eff_r;
  logic [RW-1:0]  h_eff_r;
  logic [PW-1:0]  area_r;
  logic           settle_r;
  logic           cfg_go;

  // Input position counters.
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [OCW-1:0] ocnt_r;

  // Acceptance decode.
  logic           in_go;
  logic           in_rdy;
  logic [PIX_W-1:0] px_in;
  logic           col_zero;
  logic [WW-1:0]  col_x;
  logic           big;
  logic [CW-1:0]  cm1;
  logic [WW-1:0]  r_sel;
  logic [CW-1:0]  q_sel;
  logic [OW-1:0]  row_q;
  logic [OCW:0]   cnt_inc;
  logic           col_wrap;
  ctl_t           acc_ctl;

  // Divider hookup.
  div_ctl_t       div_ctl;
  div_sts_t       div_sts;
  logic [CW-1:0]  div_quot;
  logic [WW-1:0]  div_rem;
  logic           div_ok;

  // Line store memory and bypass.
  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] lb_rd_r;
  logic               fwd_hit_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] rd_eff;
  logic [PIX_W-1:0]   up_eff;
  logic [PIX_W-1:0]   lo_eff;

  // Stage one: memory read in flight.
  logic             s1_vld_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  ctl_t             s1_ctl_r;
  logic             s1_go;
  logic             s1_free;

  // Window taps and sums.
  logic [2:0][2:0][PIX_W-1:0] taps_r;
  logic [2:0][2:0][PIX_W-1:0] taps_nxt;
  logic [2:0][SUM_W-1:0]      sum_c;
  logic                       use_tap;

  // Stage two: sums.
  logic                  s2_vld_r;
  logic [2:0][SUM_W-1:0] s2_sum_r;
  logic                  s2_last_r;
  logic                  s2_go;
  logic                  s2_free;

  // Output register.
  logic            out_vld_r;
  logic [CH_W-1:0] out_red_r;
  logic [CH_W-1:0] out_green_r;
  logic [CH_W-1:0] out_blue_r;
  logic            out_last_r;
  logic            out_free;

  // Configuration writes are always taken; inputs pause in the cycle after each.
  assign cfg_wr.ready = 1'b1;
  assign cfg_go       = cfg_wr.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r  <= clamp_w(CFG_W_BITS'(WIDTH_RESET));
      h_eff_r  <= clamp_h(CFG_DATA_W'(HEIGHT_RESET));
      settle_r <= 1'b1;
    end else begin
      settle_r <= cfg_go;
      if (cfg_go) begin
        if (cfg_wr.index == REG_FRAME_WIDTH) begin
          w_eff_r <= clamp_w(cfg_wr.data[CFG_W_BITS-1:0]);
        end else if (cfg_wr.index == REG_FRAME_HEIGHT) begin
          h_eff_r <= clamp_h(cfg_wr.data);
        end
      end
    end
  end

  // Frame area for the end-of-frame compare.
  always_ff @(posedge clk) begin
    area_r <= PW'(w_eff_r) * PW'(h_eff_r);
  end

  // Decode of the window center for the request being accepted.
  assign px_in    = (in_pix.cmd == CMD_DRAIN) ? '0
                  : {in_pix.in_red, in_pix.in_green, in_pix.in_blue};
  assign col_zero = (col_r == '0);
  assign col_x    = WW'(col_r);
  assign big      = col_x > w_eff_r;
  assign cm1      = col_r - 1'b1;
  assign r_sel    = big ? div_rem : WW'(cm1);
  assign q_sel    = big ? div_quot : '0;
  assign row_q    = OW'(row_r) + OW'(q_sel);
  assign cnt_inc  = {1'b0, ocnt_r} + 1'b1;
  assign col_wrap = (col_x + 1'b1) >= w_eff_r;

  always_comb begin
    priority if (row_r == '0) begin
      acc_ctl.has_out = big;
    end else if (row_r == RW'(1)) begin
      acc_ctl.has_out = !col_zero;
    end else begin
      acc_ctl.has_out = 1'b1;
    end
    acc_ctl.top   = col_zero ? (row_r == RW'(2)) : (row_q == OW'(1));
    acc_ctl.bot   = col_zero ? (row_r > h_eff_r) : (row_q >= OW'(h_eff_r));
    acc_ctl.left  = !col_zero && (r_sel == '0);
    acc_ctl.right = col_zero || (r_sel == (w_eff_r - 1'b1));
    acc_ctl.last  = acc_ctl.has_out && (PW'(cnt_inc) >= area_r);
  end

  // Fold a column beyond the width into rows with the serial divider.
  assign div_ctl.clear = cfg_go || in_go;
  assign div_ctl.start = big && !div_sts.busy && !div_sts.done && !cfg_go && !in_go;
  assign div_ok        = !big || div_sts.done;

  bbr_div #(
    .CW(CW),
    .WW(WW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (cm1),
    .divisor  (w_eff_r),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Input handshake.
  assign in_rdy       = s1_free && !settle_r && div_ok;
  assign in_pix.ready = in_rdy;
  assign in_go        = in_pix.valid && in_rdy;

  // Position counters; the last result of a frame restarts them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
    end else if (in_go) begin
      if (acc_ctl.last) begin
        col_r  <= '0;
        row_r  <= '0;
        ocnt_r <= '0;
      end else begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        if (acc_ctl.has_out) begin
          ocnt_r <= cnt_inc[OCW-1:0];
        end
      end
    end
  end

  // Line store: read on acceptance, write the shifted pair as stage one moves on.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      lb_mem[s1_col_r] <= {lo_eff, s1_px_r};
    end
    if (in_go) begin
      lb_rd_r <= lb_mem[col_r];
    end
  end

  // Bypass when the previous request writes the same column in the read cycle.
  assign rd_eff = fwd_hit_r ? fwd_data_r : lb_rd_r;
  assign up_eff = rd_eff[2*PIX_W-1:PIX_W];
  assign lo_eff = rd_eff[PIX_W-1:0];

  // Stage one.
  assign s1_go   = s1_vld_r && (!s1_ctl_r.has_out || s2_free);
  assign s1_free = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_go) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_px_r    <= px_in;
      s1_col_r   <= col_r;
      s1_ctl_r   <= acc_ctl;
      fwd_hit_r  <= s1_go && (s1_col_r == col_r);
      fwd_data_r <= {lo_eff, s1_px_r};
    end
  end

  // Window shift with the new right-hand column.
  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      taps_nxt[dr][0] = taps_r[dr][1];
      taps_nxt[dr][1] = taps_r[dr][2];
    end
    taps_nxt[0][2] = up_eff;
    taps_nxt[1][2] = lo_eff;
    taps_nxt[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= '0;
    end else if (s1_go) begin
      taps_r <= taps_nxt;
    end
  end

  // Per-channel sums over the in-frame taps; lane 2 is red, lane 0 is blue.
  always_comb begin
    sum_c   = '0;
    use_tap = 1'b0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        use_tap = !((dr == 0) && s1_ctl_r.top) && !((dr == 2) && s1_ctl_r.bot) &&
                  !((dc == 0) && s1_ctl_r.left) && !((dc == 2) && s1_ctl_r.right);
        for (int ch = 0; ch < 3; ch++) begin
          if (use_tap) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(taps_nxt[dr][dc][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // Stage two.
  assign s2_go   = s2_vld_r && out_free;
  assign s2_free = !s2_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s1_go && s1_ctl_r.has_out) begin
      s2_vld_r <= 1'b1;
    end else if (s2_go) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl_r.has_out) begin
      s2_sum_r  <= sum_c;
      s2_last_r <= s1_ctl_r.last;
    end
  end

  // Output register with the divide by nine.
  assign out_free = !out_vld_r || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_go) begin
      out_vld_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_red_r   <= div9(s2_sum_r[2]);
      out_green_r <= div9(s2_sum_r[1]);
      out_blue_r  <= div9(s2_sum_r[0]);
      out_last_r  <= s2_last_r;
    end
  end

  assign out_pix.valid      = out_vld_r;
  assign out_pix.out_red    = out_red_r;
  assign out_pix.out_green  = out_green_r;
  assign out_pix.out_blue   = out_blue_r;
  assign out_pix.frame_last = out_last_r;

endmodule
